@@ rtl/flptw_pkg.sv @@
// Shared types and constants of the four-level page table walker.
package flptw_pkg;

  // Request kinds carried on the input tuser
  typedef enum logic [1:0] {
    FUNC_TRANSLATE = 2'd0,
    FUNC_MAP       = 2'd1,
    FUNC_UNMAP     = 2'd2
  } func_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EXHAUSTED = 2'd1,
    STAT_MAPPED    = 2'd2
  } status_e;

  localparam int unsigned IDX_BITS = 9;
  localparam int unsigned VPN_BITS = 36;
  localparam int unsigned PPN_BITS = 40;
  localparam int unsigned ROOT_W   = 4;
  localparam int unsigned FUNC_W   = 2;

  // Low bit of each level index in the vpn, top level first
  localparam int unsigned IDX0_LSB = 27;
  localparam int unsigned IDX1_LSB = 18;
  localparam int unsigned IDX2_LSB = 9;
  localparam int unsigned IDX3_LSB = 0;

  // Input tdata layout
  localparam int unsigned IN_VPN_LSB  = 0;
  localparam int unsigned IN_PPN_LSB  = 36;
  localparam int unsigned IN_FW_BIT   = 76;
  localparam int unsigned IN_FU_BIT   = 77;
  localparam int unsigned IN_FNX_BIT  = 78;
  localparam int unsigned IN_DATA_W   = 80;
  localparam int unsigned OUT_DATA_W  = 48;
  localparam int unsigned OUT_USED_W  = 45;

  // Stored table entry: only the meaningful bits of the 64-bit format
  typedef struct packed {
    logic                noexec;
    logic [PPN_BITS-1:0] ppn;
    logic                user;
    logic                write;
    logic                present;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic clear_step;
    logic accept;
    logic rd_issue;
    logic leaf_capture;
    logic walk_step;
    logic res_load;
    logic res_fail;
    logic leaf_clear;
    logic alloc_init;
    logic alloc_step;
    logic wr_step;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic  clear_done;
    func_e func;
    logic  page_ok;
    logic  depth3;
    logic  walk_ok;
    logic  leaf_present;
    logic  alloc_done;
    logic  alloc_fail;
    logic  out_free;
  } sts_t;

endpackage

@@ rtl/flptw_ctrl.sv @@
// Sequencing state machine of the page table walker.
module flptw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  flptw_pkg::sts_t   sts_i,
  output flptw_pkg::cmd_t   cmd_o,
  input  logic              in_tvalid_i,
  output logic              in_tready_o
);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_READ   = 8'b0000_0100,
    S_CHECK  = 8'b0000_1000,
    S_DECIDE = 8'b0001_0000,
    S_ALLOC  = 8'b0010_0000,
    S_WRITE  = 8'b0100_0000,
    S_RESP   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  assign in_tready_o = (state_q == S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_READ;
        end
      end
      S_READ: begin
        if (sts_i.page_ok) begin
          cmd_o.rd_issue = 1'b1;
          state_d        = S_CHECK;
        end else begin
          state_d = S_DECIDE;
        end
      end
      S_CHECK: begin
        if (sts_i.depth3) begin
          cmd_o.leaf_capture = 1'b1;
          state_d            = S_DECIDE;
        end else if (sts_i.walk_ok) begin
          cmd_o.walk_step = 1'b1;
          state_d         = S_READ;
        end else begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd_o.res_load = 1'b1;
        state_d        = S_RESP;
        case (sts_i.func)
          flptw_pkg::FUNC_UNMAP: begin
            if (sts_i.leaf_present) cmd_o.leaf_clear = 1'b1;
          end
          flptw_pkg::FUNC_MAP: begin
            if (!sts_i.leaf_present) begin
              if (!sts_i.page_ok) begin
                cmd_o.res_fail = 1'b1;
              end else begin
                cmd_o.alloc_init = 1'b1;
                state_d          = S_ALLOC;
              end
            end
          end
          default: ;
        endcase
      end
      S_ALLOC: begin
        if (sts_i.alloc_done) begin
          state_d = S_WRITE;
        end else if (sts_i.alloc_fail) begin
          cmd_o.res_fail = 1'b1;
          state_d        = S_RESP;
        end else begin
          cmd_o.alloc_step = 1'b1;
        end
      end
      S_WRITE: begin
        cmd_o.wr_step = 1'b1;
        if (sts_i.depth3) state_d = S_RESP;
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/flptw_dp.sv @@
// Datapath of the page table walker: request registers, table store, allocator, result.
module flptw_dp #(
  parameter int unsigned TABLE_PAGES = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  flptw_pkg::cmd_t                      cmd_i,
  output flptw_pkg::sts_t                      sts_o,
  input  logic                                 cfg_we_i,
  input  logic [flptw_pkg::ROOT_W-1:0]         cfg_wdata_i,
  input  logic [flptw_pkg::IN_DATA_W-1:0]      in_tdata_i,
  input  logic [flptw_pkg::FUNC_W-1:0]         in_tuser_i,
  output logic                                 out_tvalid_o,
  output logic [flptw_pkg::OUT_DATA_W-1:0]     out_tdata_o,
  input  logic                                 out_tready_i
);

  localparam int unsigned PW      = $clog2(TABLE_PAGES);
  localparam int unsigned AW      = PW + flptw_pkg::IDX_BITS;
  localparam int unsigned ENTRIES = TABLE_PAGES * (2 ** flptw_pkg::IDX_BITS);
  localparam int unsigned CW      = $clog2(TABLE_PAGES + 1);
  localparam int unsigned KW      = (CW > flptw_pkg::ROOT_W) ? CW : flptw_pkg::ROOT_W;
  localparam int unsigned EW      = $bits(flptw_pkg::entry_t);
  localparam int unsigned PB      = flptw_pkg::PPN_BITS;
  localparam int unsigned IB      = flptw_pkg::IDX_BITS;

  // Configuration
  logic [flptw_pkg::ROOT_W-1:0] root_q;
  logic                         root_ok;

  // Request
  logic [flptw_pkg::FUNC_W-1:0]   req_func_q;
  logic [flptw_pkg::VPN_BITS-1:0] req_vpn_q;
  logic [PB-1:0]                  req_phys_q;
  logic                           req_fw_q, req_fu_q, req_fnx_q;

  // Walk
  logic [PW-1:0] page_q;
  logic          page_ok_q;
  logic [1:0]    depth_q;
  logic          leaf_present_q;
  logic [PB-1:0] leaf_ppn_q;
  logic [IB-1:0] idx;
  logic          walk_ok;

  // Allocator
  logic [CW-1:0] next_q, trial_q, trial_n, next_n;
  logic [1:0]    rem_q;
  logic          alloc_fail;

  // Store
  logic [EW-1:0]         mem [ENTRIES];
  flptw_pkg::entry_t     rdata_q;
  logic [AW-1:0]         clr_addr_q;
  logic [AW-1:0]         mem_addr;
  logic                  mem_we;
  flptw_pkg::entry_t     mem_wdata;
  flptw_pkg::entry_t     leaf_entry, table_entry;

  // Result
  logic          res_found_q, res_freed_q, res_flush_q;
  logic [PB-1:0] res_ppn_q;
  logic [1:0]    res_status_q;
  logic          out_valid_q;
  logic [flptw_pkg::OUT_DATA_W-1:0] out_data_q;

  assign root_ok = KW'(root_q) < KW'(TABLE_PAGES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
    end else if (cfg_we_i) begin
      root_q <= cfg_wdata_i;
    end
  end

  // Level index for the current depth
  always_comb begin
    case (depth_q)
      2'd0:    idx = req_vpn_q[flptw_pkg::IDX0_LSB +: IB];
      2'd1:    idx = req_vpn_q[flptw_pkg::IDX1_LSB +: IB];
      2'd2:    idx = req_vpn_q[flptw_pkg::IDX2_LSB +: IB];
      default: idx = req_vpn_q[flptw_pkg::IDX3_LSB +: IB];
    endcase
  end

  assign walk_ok = rdata_q.present && (rdata_q.ppn < PB'(TABLE_PAGES));

  // Allocator offers: skip the root page
  assign trial_n    = (KW'(trial_q) == KW'(root_q)) ? trial_q + CW'(1) : trial_q;
  assign next_n     = (KW'(next_q) == KW'(root_q)) ? next_q + CW'(1) : next_q;
  assign alloc_fail = trial_n >= CW'(TABLE_PAGES);

  // Entries written by map
  always_comb begin
    leaf_entry         = '0;
    leaf_entry.present = 1'b1;
    leaf_entry.write   = req_fw_q;
    leaf_entry.user    = req_fu_q;
    leaf_entry.noexec  = req_fnx_q;
    leaf_entry.ppn     = req_phys_q;
    table_entry         = '0;
    table_entry.present = 1'b1;
    table_entry.write   = 1'b1;
    table_entry.user    = 1'b1;
    table_entry.ppn     = PB'(next_n);
  end

  // Store port select
  always_comb begin
    mem_addr  = {page_q, idx};
    mem_we    = 1'b0;
    mem_wdata = '0;
    if (cmd_i.clear_step) begin
      mem_addr = clr_addr_q;
      mem_we   = 1'b1;
    end else if (cmd_i.leaf_clear) begin
      mem_we = 1'b1;
    end else if (cmd_i.wr_step) begin
      mem_we    = 1'b1;
      mem_wdata = (depth_q == 2'd3) ? leaf_entry : table_entry;
    end
  end

  // Table store, one access a cycle, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) rdata_q <= mem[mem_addr];
  end

  // Clearing sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clear_step && (clr_addr_q != AW'(ENTRIES - 1))) begin
      clr_addr_q <= clr_addr_q + AW'(1);
    end
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_func_q <= in_tuser_i;
      req_vpn_q  <= in_tdata_i[flptw_pkg::IN_VPN_LSB +: flptw_pkg::VPN_BITS];
      req_phys_q <= in_tdata_i[flptw_pkg::IN_PPN_LSB +: PB];
      req_fw_q   <= in_tdata_i[flptw_pkg::IN_FW_BIT];
      req_fu_q   <= in_tdata_i[flptw_pkg::IN_FU_BIT];
      req_fnx_q  <= in_tdata_i[flptw_pkg::IN_FNX_BIT];
    end
  end

  // Walk position
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      page_q         <= PW'(root_q);
      page_ok_q      <= root_ok;
      depth_q        <= 2'd0;
      leaf_present_q <= 1'b0;
      leaf_ppn_q     <= '0;
    end else if (cmd_i.walk_step) begin
      page_q  <= rdata_q.ppn[PW-1:0];
      depth_q <= depth_q + 2'd1;
    end else if (cmd_i.leaf_capture) begin
      leaf_present_q <= rdata_q.present;
      leaf_ppn_q     <= rdata_q.present ? rdata_q.ppn : '0;
    end else if (cmd_i.wr_step && (depth_q != 2'd3)) begin
      page_q  <= PW'(next_n);
      depth_q <= depth_q + 2'd1;
    end
  end

  // Trial allocation and committed counter
  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc_init) begin
      trial_q <= next_q;
      rem_q   <= 2'd3 - depth_q;
    end else if (cmd_i.alloc_step) begin
      trial_q <= trial_n + CW'(1);
      rem_q   <= rem_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_q <= '0;
    end else if (cmd_i.wr_step && (depth_q != 2'd3)) begin
      next_q <= next_n + CW'(1);
    end
  end

  // Result of the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_fail) begin
      res_found_q  <= 1'b0;
      res_ppn_q    <= '0;
      res_status_q <= flptw_pkg::STAT_EXHAUSTED;
      res_freed_q  <= 1'b0;
      res_flush_q  <= 1'b0;
    end else if (cmd_i.res_load) begin
      res_found_q  <= 1'b0;
      res_ppn_q    <= '0;
      res_status_q <= flptw_pkg::STAT_OK;
      res_freed_q  <= 1'b0;
      res_flush_q  <= 1'b0;
      case (req_func_q)
        flptw_pkg::FUNC_TRANSLATE: begin
          res_found_q <= leaf_present_q;
          res_ppn_q   <= leaf_ppn_q;
        end
        flptw_pkg::FUNC_UNMAP: begin
          res_found_q <= leaf_present_q;
          res_ppn_q   <= leaf_ppn_q;
          res_freed_q <= leaf_present_q;
          res_flush_q <= 1'b1;
        end
        flptw_pkg::FUNC_MAP: begin
          res_found_q  <= leaf_present_q;
          res_ppn_q    <= leaf_ppn_q;
          res_status_q <= leaf_present_q ? flptw_pkg::STAT_MAPPED : flptw_pkg::STAT_OK;
          res_flush_q  <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= {(flptw_pkg::OUT_DATA_W - flptw_pkg::OUT_USED_W)'(0),
                     res_flush_q, res_freed_q, res_status_q, res_ppn_q, res_found_q};
    end
  end

  assign out_tvalid_o = out_valid_q;
  assign out_tdata_o  = out_data_q;

  // Status to the controller
  always_comb begin
    sts_o              = '0;
    sts_o.clear_done   = clr_addr_q == AW'(ENTRIES - 1);
    sts_o.func         = flptw_pkg::func_e'(req_func_q);
    sts_o.page_ok      = page_ok_q;
    sts_o.depth3       = depth_q == 2'd3;
    sts_o.walk_ok      = walk_ok;
    sts_o.leaf_present = leaf_present_q;
    sts_o.alloc_done   = rem_q == 2'd0;
    sts_o.alloc_fail   = alloc_fail;
    sts_o.out_free     = !out_valid_q || out_tready_i;
  end

  // Checks
  a_alloc_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.alloc_step |-> rem_q != 2'd0)
    else $error("allocation step with nothing left to allocate");

  a_next_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_q <= CW'(TABLE_PAGES))
    else $error("allocator counter passed the store size");

  a_wr_page_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_step |-> page_ok_q)
    else $error("map write on an out-of-range table page");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_tready_i))
    else $error("result loaded over an untaken result");

  a_walk_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk_step |=> depth_q != 2'd0)
    else $error("walk depth wrapped");

endmodule

@@ rtl/four_level_page_table_walker_core.sv @@
// Top level of the four-level page table walker.
//
//  channel  | direction | tdata / tuser                                   | handshake
//  s_axis   | in        | vpn, phys_ppn, flag_write/user/noexec; tuser=func | tvalid/tready
//  m_axis   | out       | found, leaf_page, status, freed, flush_tlb        | tvalid/tready
//  cfg      | in        | root_table_page                                   | cfg_we_i
//
// One request at a time. Every level passes through a read issue and a check on the
// single-port table store, in that order, for each of the four levels of a full walk (the
// walk stops early at an absent or out-of-range entry); a map that fills an absent leaf adds
// one allocator check and one store write per missing level plus the leaf write.
// After reset a clearing sweep writes zero to all TABLE_PAGES*512 entries, one a cycle
// (8192 entries by default); s_axis_tready_o stays low for that time. A result waits in
// the output register while the next request is walked; the walker stalls only when it
// has a second result to hand.
module four_level_page_table_walker_core #(
  parameter int unsigned TABLE_PAGES = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [flptw_pkg::ROOT_W-1:0]         cfg_wdata_i,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // [35:0] vpn, [75:36] phys_ppn, [76] flag_write, [77] flag_user, [78] flag_noexec
  input  logic [flptw_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // [1:0] func
  input  logic [flptw_pkg::FUNC_W-1:0]         s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // [0] found, [40:1] leaf_page, [42:41] status, [43] freed, [44] flush_tlb
  output logic [flptw_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o
);

  flptw_pkg::cmd_t cmd;
  flptw_pkg::sts_t sts;

  flptw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_tvalid_i (s_axis_tvalid_i),
    .in_tready_o (s_axis_tready_o)
  );

  flptw_dp #(
    .TABLE_PAGES (TABLE_PAGES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_tdata_i   (s_axis_tdata_i),
    .in_tuser_i   (s_axis_tuser_i),
    .out_tvalid_o (m_axis_tvalid_o),
    .out_tdata_o  (m_axis_tdata_o),
    .out_tready_i (m_axis_tready_i)
  );

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the four-level page table walker core.
module testbench;

  localparam int unsigned TABLE_PAGES = 16;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES = 25;
  localparam logic [1:0] FUNC_RESERVED = 2'd3;

  // One walk result as the output transfer carries it
  typedef struct packed {
    logic                           found;
    logic [flptw_pkg::PPN_BITS-1:0] page;
    flptw_pkg::status_e             status;
    logic                           freed;
    logic                           flush;
  } walk_result_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             cfg_we = 1'b0;
  logic [flptw_pkg::ROOT_W-1:0]     cfg_wdata = '0;
  logic                             s_valid = 1'b0;
  logic                             s_ready;
  logic [flptw_pkg::IN_DATA_W-1:0]  s_data = '0;
  logic [flptw_pkg::FUNC_W-1:0]     s_user = '0;
  logic                             m_valid;
  logic                             m_ready = 1'b0;
  logic [flptw_pkg::OUT_DATA_W-1:0] m_data;

  // Mirror of the walker state
  bit [63:0]                  page_store [TABLE_PAGES*512];
  int unsigned                alloc_next = 0;
  bit [flptw_pkg::ROOT_W-1:0] root_page = '0;

  walk_result_t expected_walks[$];
  int           errors = 0;
  int           send_idle_pct = 0;
  int           stall_pct = 0;
  bit           hold_req = 1'b0;
  int unsigned  hold_cnt = 0;

  four_level_page_table_walker_core #(
    .TABLE_PAGES(TABLE_PAGES)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data)
  );

  always #2 clk = ~clk;

  // Run limit
  initial begin
    #1000000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [63:0] read_entry(input logic [flptw_pkg::PPN_BITS-1:0] page,
                                             input logic [flptw_pkg::IDX_BITS-1:0] idx);
    if (page >= TABLE_PAGES) return '0;
    return page_store[int'(page[15:0]) * 512 + int'(idx)];
  endfunction

  function automatic void write_entry(input logic [flptw_pkg::PPN_BITS-1:0] page,
                                      input logic [flptw_pkg::IDX_BITS-1:0] idx,
                                      input logic [63:0] value);
    if (page < TABLE_PAGES) page_store[int'(page[15:0]) * 512 + int'(idx)] = value;
  endfunction

  // Walks the mirrored tables for one request and applies its side effects
  function automatic walk_result_t walk_tables(input logic [1:0] func,
                                               input logic [flptw_pkg::VPN_BITS-1:0] vpn,
                                               input logic [flptw_pkg::PPN_BITS-1:0] phys,
                                               input logic fw, input logic fu,
                                               input logic fnx);
    walk_result_t                   r;
    logic [flptw_pkg::IDX_BITS-1:0] idx [4];
    logic [flptw_pkg::PPN_BITS-1:0] page;
    logic [63:0]                    e;
    logic [63:0]                    leaf;
    int unsigned                    depth;
    int unsigned                    trial;
    int unsigned                    need;
    int unsigned                    new_page [3];
    bit                             present;
    bit                             ok;
    bit                             walking;
    r.found = 1'b0;
    r.page = '0;
    r.status = flptw_pkg::STAT_OK;
    r.freed = 1'b0;
    r.flush = 1'b0;
    idx[0] = vpn[flptw_pkg::IDX0_LSB +: flptw_pkg::IDX_BITS];
    idx[1] = vpn[flptw_pkg::IDX1_LSB +: flptw_pkg::IDX_BITS];
    idx[2] = vpn[flptw_pkg::IDX2_LSB +: flptw_pkg::IDX_BITS];
    idx[3] = vpn[flptw_pkg::IDX3_LSB +: flptw_pkg::IDX_BITS];
    if (func == FUNC_RESERVED) return r;

    // table levels: stop at the first absent or out-of-range entry
    page = root_page;
    depth = 0;
    walking = 1'b1;
    while (walking && depth < 3) begin
      e = read_entry(page, idx[depth]);
      if (!e[0] || e[51:12] >= TABLE_PAGES) begin
        walking = 1'b0;
      end else begin
        page = e[51:12];
        depth++;
      end
    end
    leaf = '0;
    present = 1'b0;
    if (depth == 3 && page < TABLE_PAGES) begin
      leaf = read_entry(page, idx[3]);
      present = leaf[0];
    end

    case (func)
      flptw_pkg::FUNC_TRANSLATE: begin
        if (present) begin
          r.found = 1'b1;
          r.page = leaf[51:12];
        end
      end
      flptw_pkg::FUNC_UNMAP: begin
        if (present) begin
          write_entry(page, idx[3], '0);
          r.found = 1'b1;
          r.page = leaf[51:12];
          r.freed = 1'b1;
        end
        r.flush = 1'b1;
      end
      default: begin
        if (present) begin
          r.found = 1'b1;
          r.page = leaf[51:12];
          r.status = flptw_pkg::STAT_MAPPED;
          r.flush = 1'b1;
        end else begin
          // bump allocation on a trial counter, committed only if all fit
          trial = alloc_next;
          need = 3 - depth;
          ok = root_page < TABLE_PAGES;
          for (int i = 0; i < 3; i++) begin
            if (ok && i < need) begin
              if (trial == root_page) trial++;
              if (trial >= TABLE_PAGES) begin
                ok = 1'b0;
              end else begin
                new_page[i] = trial;
                trial++;
              end
            end
          end
          if (!ok) begin
            r.status = flptw_pkg::STAT_EXHAUSTED;
          end else begin
            alloc_next = trial;
            for (int i = 0; i < 3; i++) begin
              if (i < need) begin
                write_entry(page, idx[depth + i],
                            {12'b0, 40'(new_page[i]), 9'b0, 3'b111});
                page = 40'(new_page[i]);
              end
            end
            write_entry(page, idx[3], {fnx, 11'b0, phys, 9'b0, fu, fw, 1'b1});
            r.flush = 1'b1;
          end
        end
      end
    endcase
    return r;
  endfunction

  // Offers one request, waits for its transfer and records the expected walk
  task automatic send_request(input logic [1:0] func,
                              input logic [flptw_pkg::VPN_BITS-1:0] vpn,
                              input logic [flptw_pkg::PPN_BITS-1:0] phys, input logic fw,
                              input logic fu, input logic fnx);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data <= {1'b0, fnx, fu, fw, phys, vpn};
    s_user <= func;
    do @(posedge clk); while (!s_ready);
    expected_walks.push_back(walk_tables(func, vpn, phys, fw, fu, fnx));
  endtask

  // Drops valid and lets every outstanding result come back
  task automatic wait_drained();
    s_valid <= 1'b0;
    while (expected_walks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_root(input logic [flptw_pkg::ROOT_W-1:0] page);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= page;
    @(posedge clk);
    cfg_we <= 1'b0;
    root_page = page;
  endtask

  // Upper 27 vpn bits of the chains built by the directed cases
  function automatic logic [26:0] mapped_prefix(input int unsigned sel);
    case (sel)
      0: return '0;
      1: return '1;
      2: return {9'd1, 18'd0};
      3: return {9'd2, 18'd0};
      4: return {9'd1, 9'd5, 9'd0};
      5: return {9'd1, 9'd5, 9'd7};
      6: return {9'd3, 18'd0};
      default: return {9'd4, 18'd0};
    endcase
  endfunction

  // Mostly requests along existing chains with leaf indices that collide often
  task automatic run_random(input int count);
    logic [1:0]                     func;
    logic [flptw_pkg::VPN_BITS-1:0] vpn;
    logic [flptw_pkg::PPN_BITS-1:0] phys;
    int                             pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) func = FUNC_RESERVED;
      else if (pick < 8) func = flptw_pkg::FUNC_MAP;
      else if (pick < 14) func = flptw_pkg::FUNC_TRANSLATE;
      else func = flptw_pkg::FUNC_UNMAP;
      if ($urandom_range(0, 9) < 3) begin
        vpn = {4'($urandom), 32'($urandom)};
      end else begin
        vpn[35:9] = mapped_prefix($urandom_range(0, 7));
        vpn[8:0] = $urandom_range(0, 1) ? 9'($urandom_range(0, 7)) : 9'($urandom);
      end
      // small page numbers let aliased leaves act as tables
      phys = ($urandom_range(0, 9) == 0) ? 40'($urandom_range(0, 15))
                                         : {8'($urandom), 32'($urandom)};
      send_request(func, vpn, phys, 1'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  // Field extremes, every request kind, allocation and exhaustion
  task automatic test_directed_cases();
    write_root(4'd2);
    send_request(flptw_pkg::FUNC_TRANSLATE, '0, '0, 1'b0, 1'b0, 1'b0);
    send_request(flptw_pkg::FUNC_TRANSLATE, '1, '0, 1'b0, 1'b0, 1'b0);
    send_request(flptw_pkg::FUNC_UNMAP, '0, '0, 1'b0, 1'b0, 1'b0);
    // allocator skips the root page
    send_request(flptw_pkg::FUNC_MAP, '0, '0, 1'b0, 1'b0, 1'b0);
    send_request(flptw_pkg::FUNC_MAP, '0, '1, 1'b1, 1'b1, 1'b1);
    send_request(flptw_pkg::FUNC_TRANSLATE, '0, '1, 1'b0, 1'b0, 1'b0);
    send_request(flptw_pkg::FUNC_MAP, '1, '1, 1'b1, 1'b1, 1'b1);
    send_request(flptw_pkg::FUNC_TRANSLATE, '1, '0, 1'b0, 1'b0, 1'b0);
    send_request(FUNC_RESERVED, '1, '1, 1'b1, 1'b1, 1'b1);
    send_request(flptw_pkg::FUNC_UNMAP, '1, '0, 1'b0, 1'b0, 1'b0);
    send_request(flptw_pkg::FUNC_UNMAP, '1, '0, 1'b0, 1'b0, 1'b0);
    // tables still there, only the leaf is written
    send_request(flptw_pkg::FUNC_MAP, '1, 40'h5a_a55a_a55a, 1'b1, 1'b0, 1'b1);
    send_request(flptw_pkg::FUNC_MAP, 36'd1, 40'h12_3456_789a, 1'b0, 1'b1, 1'b0);
    send_request(flptw_pkg::FUNC_MAP, {9'd1, 27'd0}, 40'd77, 1'b1, 1'b0, 1'b0);
    send_request(flptw_pkg::FUNC_MAP, {9'd2, 27'd0}, 40'd3, 1'b0, 1'b0, 1'b1);
    send_request(flptw_pkg::FUNC_MAP, {9'd1, 9'd5, 18'd0}, 40'd9, 1'b1, 1'b1, 1'b0);
    // too few pages left for a whole chain: nothing changes, while a single missing table still fits
    send_request(flptw_pkg::FUNC_MAP, {9'd3, 27'd0}, 40'd1, 1'b1, 1'b1, 1'b1);
    send_request(flptw_pkg::FUNC_MAP, {9'd1, 9'd5, 9'd7, 9'd0}, 40'd2, 1'b0, 1'b1, 1'b1);
    send_request(flptw_pkg::FUNC_MAP, {9'd4, 27'd0}, 40'd4, 1'b1, 1'b1, 1'b1);
    send_request(flptw_pkg::FUNC_TRANSLATE, {9'd4, 27'd0}, '0, 1'b0, 1'b0, 1'b0);
    send_request(flptw_pkg::FUNC_UNMAP, {9'd4, 27'd0}, '0, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_free_flow();
    send_idle_pct = 0;
    stall_pct = 0;
    write_root(4'd2);
    run_random(108);
  endtask

  // Top page aliases a leaf table
  task automatic test_sender_gaps();
    send_idle_pct = 68;
    stall_pct = 0;
    write_root(4'd15);
    run_random(108);
  endtask

  // Includes a long hold-off so the walker fills and backs up its input
  task automatic test_receiver_stalls();
    send_idle_pct = 0;
    stall_pct = 68;
    write_root(4'd0);
    run_random(10);
    hold_req = 1'b1;
    run_random(98);
  endtask

  task automatic test_both_idle();
    send_idle_pct = 15;
    stall_pct = 15;
    write_root(4'd2);
    run_random(108);
  endtask

  // Result check
  always @(posedge clk) begin : result_check
    walk_result_t want;
    if (rst_n && m_valid && m_ready) begin
      if (expected_walks.size() == 0) begin
        $error("result with no request outstanding: %h", m_data);
        errors++;
      end else begin
        want = expected_walks.pop_front();
        if (m_data[0] !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, m_data[0]);
          errors++;
        end
        if (m_data[40:1] !== want.page) begin
          $error("leaf_page: expected %h, got %h", want.page, m_data[40:1]);
          errors++;
        end
        if (m_data[42:41] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_data[42:41]);
          errors++;
        end
        if (m_data[43] !== want.freed) begin
          $error("freed: expected %0d, got %0d", want.freed, m_data[43]);
          errors++;
        end
        if (m_data[44] !== want.flush) begin
          $error("flush_tlb: expected %0d, got %0d", want.flush, m_data[44]);
          errors++;
        end
      end
    end
  end

  // Receiver readiness and the long hold-off
  always @(posedge clk) begin : receiver_ready
    if (rst_n) begin
      if (hold_req) begin
        hold_cnt = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_cnt != 0) begin
        hold_cnt--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_free_flow();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    wait_drained();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/flptw_pkg.sv
rtl/flptw_ctrl.sv
rtl/flptw_dp.sv
rtl/four_level_page_table_walker_core.sv
test/testbench.sv
